/* rtl/life_generation_stencil_assert.svh */
// Assertion macros shared by the stencil RTL.
`ifndef LIFE_GENERATION_STENCIL_ASSERT_SVH
`define LIFE_GENERATION_STENCIL_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define LGS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante held.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lgs_pkg.sv */
// Package with constants, types and the B3/S23 rule for the life stencil.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    // Field and register widths
    localparam int CFG_W       = 11;
    localparam int COL_OUT_W   = 10;
    localparam int ROW_OUT_W   = 10;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // Register indexes (paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Result queue sizing
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int STALL_LEVEL = FIFO_DEPTH - 4;

    // Rule tables indexed by live-neighbor count
    localparam logic [8:0] BIRTH_RULE   = 9'b0_0000_1000;
    localparam logic [8:0] SURVIVE_RULE = 9'b0_0000_1100;

    // One result transfer
    typedef struct packed {
        logic                 next_alive;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
        logic                 frame_last;
    } res_t;

    // Apply B3/S23 to a 3x3 window; bit 4 is the center cell
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] count;
        count = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + 4'(win[i]);
            end
        end
        return win[4] ? SURVIVE_RULE[count] : BIRTH_RULE[count];
    endfunction

endpackage

`default_nettype wire

/* rtl/life_generation_stencil.sv */
// Streaming B3/S23 next-generation stencil with two line stores and a 3x3 window.
// Pipeline: a cell is registered with its line-store read, then the window update pushes
// its results into an 8-entry result queue.
// Throughput: one cell per cycle; the last cell of a row yields two results, drained by the
// following first-column cell, which yields none. Input stalls only when the queue backs up.
// Reset: counters, window, pipeline valid and queue clear at once; line stores hold no reset.
`timescale 1ns / 1ps
`default_nettype none
`include "life_generation_stencil_assert.svh"

module life_generation_stencil #(
    parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // cell stream
    input  wire logic                          cell_valid,
    output logic                               cell_stall,
    input  wire logic                          alive,
    // result stream
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               next_alive,
    output logic [lgs_pkg::COL_OUT_W-1:0]      column,
    output logic [lgs_pkg::ROW_OUT_W-1:0]      row,
    output logic                               frame_last,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lgs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lgs_pkg::PDATA_W-1:0]   pwdata,
    output logic [lgs_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int ColW    = $clog2(MAX_WIDTH);
    localparam int WUsedW  = $clog2(MAX_WIDTH + 1);
    localparam int RowCntW = $clog2(MAX_HEIGHT + 1);
    localparam int CmpA    = (WUsedW > RowCntW) ? WUsedW : RowCntW;
    localparam int CmpW    = (CmpA > lgs_pkg::CFG_W) ? CmpA : lgs_pkg::CFG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lgs_pkg::CFG_W-1:0] frame_width_reg;
    logic [lgs_pkg::CFG_W-1:0] frame_height_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lgs_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= lgs_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                lgs_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[lgs_pkg::CFG_W-1:0];
                lgs_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[lgs_pkg::CFG_W-1:0];
            endcase
        end
    end

    // Return the selected register
    always_comb
    begin
        unique case (paddr[2])
            lgs_pkg::REG_FRAME_WIDTH:  prdata = lgs_pkg::PDATA_W'(frame_width_reg);
            lgs_pkg::REG_FRAME_HEIGHT: prdata = lgs_pkg::PDATA_W'(frame_height_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Frame geometry and raster counters
    // ------------------------------------------------------------------
    logic [ColW-1:0]    column_count_reg, column_count_next;
    logic [RowCntW-1:0] row_count_reg, row_count_next;
    logic [CmpW-1:0]    w_used, h_used, fw_ext, fh_ext;
    logic [CmpW-1:0]    col_ext, row_ext, x_ext, y_ext, y_m1_ext;
    logic               restart;
    logic [ColW-1:0]    x;
    logic [RowCntW-1:0] y;
    logic               x_last;
    logic               y_last;
    logic               cell_accept;

    assign cell_accept = cell_valid && !cell_stall;

    // Clamp the frame size and locate the incoming cell
    always_comb
    begin
        fw_ext = CmpW'(frame_width_reg);
        fh_ext = CmpW'(frame_height_reg);
        if (fw_ext < CmpW'(2))
            w_used = CmpW'(2);
        else if (fw_ext > CmpW'(MAX_WIDTH))
            w_used = CmpW'(MAX_WIDTH);
        else
            w_used = fw_ext;
        if (fh_ext < CmpW'(1))
            h_used = CmpW'(1);
        else if (fh_ext > CmpW'(MAX_HEIGHT))
            h_used = CmpW'(MAX_HEIGHT);
        else
            h_used = fh_ext;

        col_ext = CmpW'(column_count_reg);
        row_ext = CmpW'(row_count_reg);
        restart = (col_ext >= w_used) || (row_ext > h_used);
        x       = restart ? '0 : column_count_reg;
        y       = restart ? '0 : row_count_reg;
        x_ext   = CmpW'(x);
        y_ext   = CmpW'(y);
        y_m1_ext = y_ext - CmpW'(1);
        x_last  = (x_ext == (w_used - CmpW'(1)));
        y_last  = (y_ext == h_used);

        // Advance the raster position
        if (x_last)
        begin
            column_count_next = '0;
            row_count_next    = y_last ? '0 : RowCntW'(y + 1'b1);
        end
        else
        begin
            column_count_next = ColW'(x + 1'b1);
            row_count_next    = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (cell_accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: bit 0 = row above, bit 1 = two rows above
    // ------------------------------------------------------------------
    logic [1:0] line_mem [MAX_WIDTH];
    logic [1:0] line_rd_reg;

    // Stage 1 registers
    logic                      s1_valid_reg;
    logic [ColW-1:0]           s1_col_reg;
    logic [lgs_pkg::ROW_OUT_W-1:0] s1_row_reg;
    logic                      s1_cur_reg;
    logic                      s1_has_mid_reg;
    logic                      s1_has_top_reg;
    logic                      s1_first_col_reg;
    logic                      s1_last_col_reg;
    logic                      s1_last_row_reg;

    // Read the column's history as the cell is taken
    always_ff @(posedge clk)
    begin
        if (cell_accept)
            line_rd_reg <= line_mem[x];
    end

    // Shift the column history down by one row
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= {line_rd_reg[0], s1_cur_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= cell_accept;
    end

    // Capture the cell and its position flags
    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            s1_col_reg       <= x;
            s1_row_reg       <= y_m1_ext[lgs_pkg::ROW_OUT_W-1:0];
            s1_cur_reg       <= (y_ext < h_used) ? alive : 1'b0;
            s1_has_mid_reg   <= (y_ext >= CmpW'(1));
            s1_has_top_reg   <= (y_ext >= CmpW'(2));
            s1_first_col_reg <= (x_ext == '0);
            s1_last_col_reg  <= x_last;
            s1_last_row_reg  <= y_last;
        end
    end

    // ------------------------------------------------------------------
    // Window update and rule evaluation
    // ------------------------------------------------------------------
    logic [8:0]      window_reg, window_next;
    logic [2:0]      col_bits;
    logic [CmpW-1:0] s1_col_ext, s1_col_m1;
    logic            r0_valid, r1_valid;
    lgs_pkg::res_t   r0, r1;

    always_comb
    begin
        col_bits[0] = s1_has_top_reg ? line_rd_reg[1] : 1'b0;
        col_bits[1] = s1_has_mid_reg ? line_rd_reg[0] : 1'b0;
        col_bits[2] = s1_cur_reg;
        if (s1_first_col_reg)
            window_next = {col_bits, 6'b0};
        else
            window_next = {col_bits, window_reg[8:3]};

        s1_col_ext = CmpW'(s1_col_reg);
        s1_col_m1  = s1_col_ext - CmpW'(1);

        r0_valid = s1_valid_reg && s1_has_mid_reg && !s1_first_col_reg;
        r1_valid = s1_valid_reg && s1_has_mid_reg && s1_last_col_reg;

        // Cell left of the incoming column
        r0.next_alive = lgs_pkg::life_rule(window_next);
        r0.column     = s1_col_m1[lgs_pkg::COL_OUT_W-1:0];
        r0.row        = s1_row_reg;
        r0.frame_last = 1'b0;

        // Last cell of the row, right edge dead
        r1.next_alive = lgs_pkg::life_rule({3'b000, window_next[8:3]});
        r1.column     = s1_col_ext[lgs_pkg::COL_OUT_W-1:0];
        r1.row        = s1_row_reg;
        r1.frame_last = s1_last_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (s1_valid_reg)
            window_reg <= window_next;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    lgs_pkg::res_t                   fifo_reg [lgs_pkg::FIFO_DEPTH];
    logic [lgs_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lgs_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lgs_pkg::FIFO_PTR_W-1:0]  wr_ptr_inc;
    logic [lgs_pkg::FIFO_CNT_W-1:0]  fifo_count_reg, fifo_count_next;
    logic [1:0]                      n_push;
    logic                            pop;
    lgs_pkg::res_t                   head;

    assign result_valid = (fifo_count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign cell_stall   = (fifo_count_reg > lgs_pkg::FIFO_CNT_W'(lgs_pkg::STALL_LEVEL));
    assign wr_ptr_inc   = lgs_pkg::FIFO_PTR_W'(wr_ptr_reg + 1'b1);

    always_comb
    begin
        n_push          = 2'(r0_valid) + 2'(r1_valid);
        wr_ptr_next     = lgs_pkg::FIFO_PTR_W'(wr_ptr_reg + n_push);
        rd_ptr_next     = lgs_pkg::FIFO_PTR_W'(rd_ptr_reg + pop);
        fifo_count_next = lgs_pkg::FIFO_CNT_W'(fifo_count_reg + n_push - pop);
    end

    // Push up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (r0_valid)
            fifo_reg[wr_ptr_reg] <= r0;
        if (r1_valid)
            fifo_reg[wr_ptr_inc] <= r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    // Drive the head of the queue
    assign head       = fifo_reg[rd_ptr_reg];
    assign next_alive = head.next_alive;
    assign column     = head.column;
    assign row        = head.row;
    assign frame_last = head.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LGS_ASSERT_SAME(a_fifo_bound, 1'b1,
        fifo_count_reg <= lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH),
        "result queue overflow")
    `LGS_ASSERT_SAME(a_pair_order, r1_valid, r0_valid,
        "row-end result without its left neighbor")
    `LGS_ASSERT_NEXT(a_stage_fill, cell_accept, s1_valid_reg,
        "accepted cell did not reach the window stage")

endmodule

`default_nettype wire

/* dv/life_generation_stencil_checker.sv */
// Scoreboard for the life stencil: mirrors the frame size registers, predicts results, compares.
`timescale 1ns / 1ps

module life_generation_stencil_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cell_valid,
    input  logic                              cell_stall,
    input  logic                              alive,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic                              next_alive,
    input  logic [lgs_pkg::COL_OUT_W-1:0]     column,
    input  logic [lgs_pkg::ROW_OUT_W-1:0]     row,
    input  logic                              frame_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lgs_pkg::PADDR_W-1:0]       paddr,
    input  logic [lgs_pkg::PDATA_W-1:0]       pwdata,
    input  logic [lgs_pkg::PDATA_W-1:0]       prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending,
    output int                                checked_count,
    output logic                              frame_start
);

    localparam int WMAX = lgs_pkg::MAX_WIDTH_DEF;
    localparam int HMAX = lgs_pkg::MAX_HEIGHT_DEF;

    // Shadow copy of the frame size registers
    logic [lgs_pkg::CFG_W-1:0] width_reg;
    logic [lgs_pkg::CFG_W-1:0] height_reg;

    // Predicted stencil state
    bit                        row_above [WMAX];
    bit                        row_two_above [WMAX];
    logic [8:0]                window;
    int unsigned               col_cnt;
    int unsigned               row_cnt;
    lgs_pkg::res_t             next_gen_q [$];

    initial
    begin
        fail_count    = 0;
        checked_count = 0;
        pending       = 0;
        frame_start   = 1'b1;
    end

    function automatic int unsigned width_used();
        if (width_reg < 2) return 2;
        if (width_reg > WMAX) return WMAX;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned height_used();
        if (height_reg < 1) return 1;
        if (height_reg > HMAX) return HMAX;
        return 32'(height_reg);
    endfunction

    // B3/S23 on the window; bit 4 is the cell itself, the other eight its neighbors
    function automatic logic life_next(input logic [8:0] win);
        int neighbors;
        neighbors = 0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4 && win[i]) neighbors++;
        end
        if (win[4]) return (neighbors == 2 || neighbors == 3);
        return (neighbors == 3);
    endfunction

    function automatic void push_result(input int unsigned col, input int unsigned rw,
                                        input logic last);
        lgs_pkg::res_t r;
        r.next_alive = life_next(window);
        r.column     = col[lgs_pkg::COL_OUT_W-1:0];
        r.row        = rw[lgs_pkg::ROW_OUT_W-1:0];
        r.frame_last = last;
        next_gen_q.push_back(r);
    endfunction

    // Take one cell: shift the line stores and window, queue the results it completes
    task automatic advance_generation(input logic live);
        int unsigned w, h, x, y;
        logic        cur, top, mid;
        w = width_used();
        h = height_used();
        if (col_cnt >= w || row_cnt > h)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        x = col_cnt;
        y = row_cnt;
        // the flush row enters as dead cells
        cur = (y < h) ? live : 1'b0;
        top = (y >= 2) ? row_two_above[x] : 1'b0;
        mid = (y >= 1) ? row_above[x] : 1'b0;
        row_two_above[x] = row_above[x];
        row_above[x]     = cur;
        if (x == 0) window = {cur, mid, top, 6'b0};
        else window = {cur, mid, top, window[8:3]};
        if (y >= 1)
        begin
            if (x >= 1) push_result(x - 1, y - 1, 1'b0);
            // last column: shift in a dead column beyond the edge
            if (x == w - 1)
            begin
                window = window >> 3;
                push_result(x, y - 1, y == h);
            end
        end
        x++;
        if (x == w)
        begin
            x = 0;
            y++;
            if (y > h) y = 0;
        end
        col_cnt = x;
        row_cnt = y;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lgs_pkg::res_t want;
        logic [lgs_pkg::CFG_W-1:0] reg_value;
        if (!rst_n)
        begin
            width_reg  = lgs_pkg::FRAME_WIDTH_RST;
            height_reg = lgs_pkg::FRAME_HEIGHT_RST;
            window     = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            next_gen_q.delete();
        end
        else
        begin
            // register access: track writes, check read-back
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == lgs_pkg::REG_FRAME_WIDTH)
                        width_reg = pwdata[lgs_pkg::CFG_W-1:0];
                    else
                        height_reg = pwdata[lgs_pkg::CFG_W-1:0];
                end
                else
                begin
                    reg_value = (paddr[2] == lgs_pkg::REG_FRAME_WIDTH) ? width_reg : height_reg;
                    if (prdata !== 32'(reg_value))
                        report_mismatch("register read-back", prdata, 32'(reg_value));
                end
            end
            // result transfer: compare against the oldest expectation
            if (result_valid && !result_stall)
            begin
                checked_count++;
                if (next_gen_q.size() == 0)
                begin
                    report_mismatch("result with none expected, column", 32'(column), 32'd0);
                end
                else
                begin
                    want = next_gen_q.pop_front();
                    if (next_alive !== want.next_alive)
                        report_mismatch($sformatf("next_alive at (%0d,%0d)",
                                                  want.column, want.row),
                                        32'(next_alive), 32'(want.next_alive));
                    if (column !== want.column)
                        report_mismatch("column", 32'(column), 32'(want.column));
                    if (row !== want.row)
                        report_mismatch("row", 32'(row), 32'(want.row));
                    if (frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame_last at (%0d,%0d)",
                                                  want.column, want.row),
                                        32'(frame_last), 32'(want.frame_last));
                end
            end
            // cell transfer: advance the prediction
            if (cell_valid && !cell_stall) advance_generation(alive);
        end
        pending     = next_gen_q.size();
        frame_start = (col_cnt == 0 && row_cnt == 0) || col_cnt >= width_used()
                      || row_cnt > height_used();
    end

endmodule

/* dv/tb_life_generation_stencil.sv */
// Top-level testbench for the life stencil: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_life_generation_stencil;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int PARTIAL_CELLS  = 64;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cell_valid = 1'b0;
    logic                              cell_stall;
    logic                              alive = 1'b0;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    logic                              next_alive;
    logic [lgs_pkg::COL_OUT_W-1:0]     column;
    logic [lgs_pkg::ROW_OUT_W-1:0]     row;
    logic                              frame_last;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [lgs_pkg::PADDR_W-1:0]       paddr = '0;
    logic [lgs_pkg::PDATA_W-1:0]       pwdata = '0;
    logic [lgs_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;

    int                                fail_count;
    int                                pending;
    int                                checked_count;
    logic                              frame_start;

    int                                cells_sent = 0;
    int                                width_now = 640;
    int                                hold_requests = 0;
    int                                hold_served = 0;
    int                                quiet_cycles = 0;
    bit                                calm = 1'b0;

    life_generation_stencil dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .alive        (alive),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .next_alive   (next_alive),
        .column       (column),
        .row          (row),
        .frame_last   (frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    life_generation_stencil_checker generation_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_valid    (cell_valid),
        .cell_stall    (cell_stall),
        .alive         (alive),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .next_alive    (next_alive),
        .column        (column),
        .row           (row),
        .frame_last    (frame_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .frame_start   (frame_start)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cell_valid && !cell_stall) || (result_valid && !result_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] timeout: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result sink: hold result_stall for a random gap, or a long hold when requested, before each transfer
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_served < hold_requests)
            begin
                gap = LONG_HOLD;
                hold_served++;
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 11);
            end
            if (gap != 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // Offer one cell after a random gap and hold it until the transfer
    task automatic send_cell(input logic live);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        alive      <= live;
        cell_valid <= 1'b1;
        do @(posedge clk); while (cell_stall);
        @(negedge clk);
        cells_sent++;
    endtask

    // Send cells with the given density (0 dead .. 4 all alive) up to the next frame boundary
    task automatic run_frame(input int density);
        do send_cell($urandom_range(0, 3) < density);
        while (!frame_start);
    endtask

    // Drop valid and wait until every predicted result has left the block
    task automatic settle();
        cell_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A setup phase, then an access phase until pready, then release the bus
    task automatic apb_access(input logic is_write, input logic idx,
                              input logic [lgs_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write a register with random upper bus bits, then read it back
    task automatic write_reg(input logic idx, input logic [lgs_pkg::CFG_W-1:0] value);
        logic [lgs_pkg::PDATA_W-1:0] data;
        data = $urandom();
        data[lgs_pkg::CFG_W-1:0] = value;
        apb_access(1'b1, idx, data);
        apb_access(1'b0, idx, '0);
    endtask

    task automatic set_frame_size(input logic [lgs_pkg::CFG_W-1:0] w_val,
                                  input logic [lgs_pkg::CFG_W-1:0] h_val);
        settle();
        write_reg(lgs_pkg::REG_FRAME_WIDTH, w_val);
        write_reg(lgs_pkg::REG_FRAME_HEIGHT, h_val);
        width_now = (w_val < 2) ? 2 : (w_val > lgs_pkg::MAX_WIDTH_DEF) ?
                    lgs_pkg::MAX_WIDTH_DEF : int'(w_val);
    endtask

    // Hold off the sink for a long stretch while the source keeps offering cells
    task automatic apply_backpressure();
        set_frame_size(11'd12, 11'd6);
        hold_requests++;
        calm = 1'b1;
        run_frame(2);
        calm = 1'b0;
    endtask

    initial
    begin : stimulus
        int random_base;
        int density;
        int w_val;
        int h_val;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Blinker in a 3x3 frame; the flush row carries live values that must be ignored
        set_frame_size(11'd3, 11'd3);
        for (int i = 0; i < 12; i++) send_cell(i % 3 == 1);

        // Shrink the width mid-row so the column count forces a restart (width below minimum)
        set_frame_size(11'd3, 11'd1);
        send_cell(1'b1);
        send_cell(1'b1);
        set_frame_size(11'd1, 11'd1);
        run_frame(4);

        // Shrink the height during the flush row so the row count forces a restart
        set_frame_size(11'd2, 11'd2);
        repeat (4) send_cell(1'b1);
        set_frame_size(11'd2, 11'd0);
        run_frame(4);

        // Random frames, mostly small, with back-to-back frames and broken sequences
        random_base = cells_sent;
        apply_backpressure();
        while (cells_sent - random_base < RANDOM_ITEMS)
        begin
            if (hold_requests < 2 && cells_sent - random_base >= RANDOM_ITEMS / 2)
                apply_backpressure();
            density = $urandom_range(0, 4);
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        w_val = $urandom_range(0, 1);
                        h_val = $urandom_range(0, 4);
                    end
                    1:
                    begin
                        w_val = $urandom_range(13, 64);
                        h_val = $urandom_range(1, 2);
                    end
                    default:
                    begin
                        w_val = $urandom_range(2, 12);
                        h_val = $urandom_range(0, 8);
                    end
                endcase
                set_frame_size(11'(w_val), 11'(h_val));
            end
            // Broken sequence: stop part way, shrink or keep the width, change the height
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 2 * width_now)) send_cell(1'($urandom_range(0, 1)));
                set_frame_size(11'($urandom_range(2, width_now)), 11'($urandom_range(0, 8)));
            end
            run_frame(density);
        end
        calm = 1'b0;

        // Clamped sizes: part of a widest row, then the top of a tallest column, each cut short
        set_frame_size(11'd2047, 11'd0);
        repeat (PARTIAL_CELLS) send_cell(1'($urandom_range(0, 1)));
        set_frame_size(11'd2, 11'd2047);
        repeat (2 * PARTIAL_CELLS) send_cell(1'($urandom_range(0, 1)));
        set_frame_size(11'd2, 11'd1);
        run_frame(3);

        // Drain and let any stray result show up
        cell_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d cell transfers and %0d checked results, %0d mismatches.",
                 cells_sent, checked_count, fail_count);
        $display("Frames up to 64 wide, clamped sizes, mid-frame resizes and long output stalls.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
